@@ src/bde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg
// shared constants for the bit deposit / extract unit
// ----------------------------------------------------------------------------
package bde_pkg;

	// default datapath width
	localparam int WORD_BITS_DEF = 64;

	// mask bits counted together in the first stage
	localparam int GROUP_BITS = 8;

	// operation codes carried in tuser
	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

endpackage

@@ src/bit_deposit_extract_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_deposit_extract_unit
// pipelined parallel bit deposit (pdep) and bit extract (pext)
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side is not stalled and returns
// one result word per input word, in order, through three register stages:
// mask bit counting in groups of eight, rank computation (group offset plus
// local count), and the scatter / gather select feeding the output register.
// Each stage holds its word when the next stage is full and stalled, so
// back-pressure on m_tready never drops or repeats a word, and the input
// keeps taking words as long as a bubble exists somewhere in the pipe.
// s_tuser selects the operation: low for deposit (low source bits placed at
// the set mask positions, lowest first), high for extract (source bits at the
// set mask positions packed at the low end). Result bits not written are
// zero; an empty mask gives zero.
module bit_deposit_extract_unit
	import bde_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input word
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// source_word, select_mask (lowest bits first), zero padded to bytes
	input  logic [((2*WORD_BITS+7)/8)*8-1:0]        s_tdata,
	// req_type
	input  logic                                    s_tuser,
	// result word
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// result_word, zero padded to bytes
	output logic [((WORD_BITS+7)/8)*8-1:0]          m_tdata
);

	localparam int OUT_W = ((WORD_BITS + 7) / 8) * 8;
	localparam int NUM_GROUPS = (WORD_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int RANK_W = $clog2(WORD_BITS);
	localparam int LOC_W = $clog2(GROUP_BITS);
	localparam int GCNT_W = LOC_W + 1;

	// per-stage advance enables, chained back from the output
	logic en1, en2, en3;

	// stage valids
	logic v_s1, v_s2;

	// input fields
	logic [WORD_BITS-1:0] src_in, msk_in;

	// stage 1 registers
	logic                 op_s1;
	logic [WORD_BITS-1:0] src_s1, msk_s1;
	logic [LOC_W-1:0]     loc_s1  [WORD_BITS];
	logic [GCNT_W-1:0]    gcnt_s1 [NUM_GROUPS];

	// stage 2 registers
	logic                 op_s2;
	logic [WORD_BITS-1:0] src_s2, msk_s2;
	logic [RANK_W-1:0]    rank_s2 [WORD_BITS];

	// stage 3 is the output register
	logic [WORD_BITS-1:0] res_s3;

	// combinational results of each stage
	logic [LOC_W-1:0]     loc_c  [WORD_BITS];
	logic [GCNT_W-1:0]    gcnt_c [NUM_GROUPS];
	logic [RANK_W-1:0]    rank_c [WORD_BITS];
	logic [WORD_BITS-1:0] res_c;

	assign src_in = s_tdata[WORD_BITS-1:0];
	assign msk_in = s_tdata[2*WORD_BITS-1:WORD_BITS];

	// a stage moves on when it is empty or the next one moves
	assign en3      = !m_tvalid || m_tready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	assign m_tdata = OUT_W'(res_s3);

	// stage 1: exclusive count of set mask bits inside each group
	always_comb begin
		logic [GCNT_W-1:0] cnt;
		cnt = '0;
		for (int g = 0; g < NUM_GROUPS; g++) gcnt_c[g] = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (i % GROUP_BITS == 0) cnt = '0;
			loc_c[i] = cnt[LOC_W-1:0];
			cnt = cnt + GCNT_W'(msk_in[i]);
			gcnt_c[i / GROUP_BITS] = cnt;
		end
	end

	// stage 2: group offsets plus local count give each position its rank
	always_comb begin
		logic [RANK_W:0] acc;
		logic [RANK_W:0] off [NUM_GROUPS];
		acc = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			off[g] = acc;
			acc = acc + (RANK_W+1)'(gcnt_s1[g]);
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			rank_c[i] = RANK_W'(off[i / GROUP_BITS] + (RANK_W+1)'(loc_s1[i]));
		end
	end

	// stage 3: deposit reads source bit at rank, extract writes bit at rank
	always_comb begin
		logic [WORD_BITS-1:0] dep;
		logic [WORD_BITS-1:0] ext;
		logic [WORD_BITS-1:0] hit;
		hit = msk_s2 & src_s2;
		for (int i = 0; i < WORD_BITS; i++) begin
			dep[i] = msk_s2[i] & src_s2[rank_s2[i]];
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			ext[j] = 1'b0;
			for (int i = 0; i < WORD_BITS; i++) begin
				ext[j] = ext[j] | (hit[i] & (rank_s2[i] == RANK_W'(j)));
			end
		end
		res_c = (op_s2 == OP_EXTRACT) ? ext : dep;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) m_tvalid <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1  <= s_tuser;
			src_s1 <= src_in;
			msk_s1 <= msk_in;
			loc_s1 <= loc_c;
			gcnt_s1 <= gcnt_c;
		end
		if (en2) begin
			op_s2   <= op_s1;
			src_s2  <= src_s1;
			msk_s2  <= msk_s1;
			rank_s2 <= rank_c;
		end
		if (en3) begin
			res_s3 <= res_c;
		end
	end

	// an empty pipe always takes a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !m_tvalid) |-> s_tready)
		else $error("input stalled with an empty pipe");

	// an accepted word lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word lost before stage 1");

	// a new result only appears when stage 2 held a word
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 == 1'b0 && en3) |=> !m_tvalid)
		else $error("result word without a word in stage 2");

	// a stalled output word is not overwritten by stage 2
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && v_s2) |=> (m_tvalid && v_s2))
		else $error("word dropped under output stall");

endmodule
